// ===== src/swfs_pkg.sv =====
// Package for the stop-and-wait fragment sender.
// Holds event, reply and action codes plus the config register indexes.
// No dependencies.
package swfs_pkg;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_REPLY   = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_NACK  = 2'd1,
    KIND_OTHER = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ACT_SEND   = 2'd0,
    ACT_DONE   = 2'd1,
    ACT_ABORT  = 2'd2,
    ACT_IGNORE = 2'd3
  } action_t;

  localparam logic [1:0] REG_MESSAGE_BYTES = 2'd0;
  localparam logic [1:0] REG_SESSION       = 2'd1;
  localparam logic [1:0] REG_RETRY_LIMIT   = 2'd2;

  localparam int unsigned BYTES_W = 24;
  localparam int unsigned FRAG_W  = 16;
  localparam int unsigned CHUNK_W = 9;
  localparam int unsigned RETRY_W = 8;
  localparam int unsigned SESS_W  = 16;
  localparam int unsigned SEQ_W   = 32;

endpackage

// ===== src/stop_and_wait_fragment_sender.sv =====
// Stop-and-wait fragment sender: transfer state, retry counting, result register.
// Depends on swfs_pkg.
// An accepted item's result is loaded into the output register in the next cycle.
// It takes one item per cycle; the output register is the only stage, and the
// input stalls only while that register holds a result that is not taken.
// Reset (synchronous, active high) clears the transfer state and output valid,
// and sets message_bytes 0, session_number 0, retry_limit 3.
module stop_and_wait_fragment_sender
  import swfs_pkg::*;
#(
  parameter int unsigned FRAGMENT_BYTES = 479
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [BYTES_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           op,
  input  logic                 frame_good,
  input  logic [SESS_W-1:0]    reply_session,
  input  logic [1:0]           reply_kind,
  input  logic [SEQ_W-1:0]     reply_sequence,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           action,
  output logic [FRAG_W-1:0]    fragment_number,
  output logic [BYTES_W-1:0]   byte_offset,
  output logic [CHUNK_W-1:0]   chunk_length,
  output logic [RETRY_W-1:0]   attempt_count
);

  localparam logic [BYTES_W:0] FRAG_LEN = (BYTES_W+1)'(FRAGMENT_BYTES);

  logic [BYTES_W-1:0] message_bytes;
  logic [SESS_W-1:0]  session_number;
  logic [RETRY_W-1:0] retry_limit;

  logic               busy, busy_next;
  logic [FRAG_W-1:0]  current_fragment, current_fragment_next;
  logic [BYTES_W-1:0] current_offset, current_offset_next;
  logic [RETRY_W-1:0] retries_used, retries_used_next;

  action_t            act_next;
  logic               describe;
  logic               in_accept;
  logic               ack_ok;
  logic [BYTES_W:0]   offset_sum;
  logic [RETRY_W-1:0] retries_inc;
  logic [BYTES_W:0]   left;
  logic [BYTES_W:0]   chunk_full;
  logic [CHUNK_W-1:0] chunk_next;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      message_bytes  <= '0;
      session_number <= '0;
      retry_limit    <= RETRY_W'(3);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MESSAGE_BYTES: message_bytes  <= cfg_data;
        REG_SESSION:       session_number <= cfg_data[SESS_W-1:0];
        REG_RETRY_LIMIT:   retry_limit    <= cfg_data[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  assign ack_ok = (op_t'(op) == OP_REPLY) && frame_good
                  && (reply_session == session_number)
                  && (kind_t'(reply_kind) == KIND_ACK)
                  && (reply_sequence == {{(SEQ_W-FRAG_W){1'b0}}, current_fragment});
  assign offset_sum  = {1'b0, current_offset} + FRAG_LEN;
  assign retries_inc = (retries_used == '1) ? retries_used : retries_used + RETRY_W'(1);

  always_comb begin
    busy_next             = busy;
    current_fragment_next = current_fragment;
    current_offset_next   = current_offset;
    retries_used_next     = retries_used;
    act_next              = ACT_IGNORE;
    describe              = 1'b0;
    case (op_t'(op))
      OP_START: begin
        current_fragment_next = '0;
        current_offset_next   = '0;
        retries_used_next     = '0;
        if (message_bytes == '0) begin
          busy_next = 1'b0;
          act_next  = ACT_DONE;
        end else if (retry_limit == '0) begin
          busy_next = 1'b0;
          act_next  = ACT_ABORT;
          describe  = 1'b1;
        end else begin
          busy_next = 1'b1;
          act_next  = ACT_SEND;
          describe  = 1'b1;
        end
      end
      OP_REPLY, OP_TIMEOUT: begin
        if (busy) begin
          if (ack_ok) begin
            if (offset_sum >= {1'b0, message_bytes}) begin
              busy_next             = 1'b0;
              current_fragment_next = '0;
              current_offset_next   = '0;
              retries_used_next     = '0;
              act_next              = ACT_DONE;
            end else begin
              current_offset_next   = offset_sum[BYTES_W-1:0];
              current_fragment_next = current_fragment + FRAG_W'(1);
              retries_used_next     = '0;
              act_next              = ACT_SEND;
              describe              = 1'b1;
            end
          end else begin
            retries_used_next = retries_inc;
            describe          = 1'b1;
            if (retries_inc >= retry_limit) begin
              busy_next = 1'b0;
              act_next  = ACT_ABORT;
            end else begin
              act_next = ACT_SEND;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // chunk of the fragment described by the next state
  always_comb begin
    left = {1'b0, message_bytes} - {1'b0, current_offset_next};
    if (current_offset_next >= message_bytes) begin
      chunk_full = '0;
    end else if (left < FRAG_LEN) begin
      chunk_full = left;
    end else begin
      chunk_full = FRAG_LEN;
    end
    chunk_next = chunk_full[CHUNK_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy             <= 1'b0;
      current_fragment <= '0;
      current_offset   <= '0;
      retries_used     <= '0;
    end else if (in_accept) begin
      busy             <= busy_next;
      current_fragment <= current_fragment_next;
      current_offset   <= current_offset_next;
      retries_used     <= retries_used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      action <= act_next;
      if (describe) begin
        fragment_number <= current_fragment_next;
        byte_offset     <= current_offset_next;
        chunk_length    <= chunk_next;
        attempt_count   <= retries_used_next;
      end else begin
        fragment_number <= '0;
        byte_offset     <= '0;
        chunk_length    <= '0;
        attempt_count   <= '0;
      end
    end
  end

  a_empty_done: assert property (@(posedge clk) disable iff (rst)
    in_accept && op_t'(op) == OP_START && message_bytes == '0
    |=> out_valid && action_t'(action) == ACT_DONE && !busy)
    else $error("empty message start did not finish");

  a_idle_ignore: assert property (@(posedge clk) disable iff (rst)
    in_accept && !busy && op_t'(op) != OP_START
    |=> action_t'(action) == ACT_IGNORE && !busy)
    else $error("event while idle not ignored");

  a_abort_idle: assert property (@(posedge clk) disable iff (rst)
    in_accept && act_next == ACT_ABORT |=> !busy)
    else $error("abort left transfer active");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (action_t'(action) == ACT_DONE || action_t'(action) == ACT_IGNORE)
    |-> fragment_number == '0 && byte_offset == '0 && chunk_length == '0
        && attempt_count == '0)
    else $error("done or ignore result carries fragment fields");

  a_send_busy: assert property (@(posedge clk) disable iff (rst)
    in_accept && act_next == ACT_SEND |=> busy)
    else $error("send issued without an active transfer");

endmodule

// ===== tb/sv/stop_and_wait_fragment_sender_test.sv =====
// Self-checking test for the stop-and-wait fragment sender: directed corner cases,
// then random transfers checked against a transfer tracker with a result queue.
// Depends on swfs_pkg and stop_and_wait_fragment_sender.
`timescale 1ns / 100ps

module stop_and_wait_fragment_sender_test;
  import swfs_pkg::*;

  localparam int unsigned FRAG_BYTES      = 479;
  localparam int unsigned PHASES          = 13;
  localparam int unsigned ITEMS_PER_PHASE = 140;
  localparam int unsigned HOLD_CYCLES     = 300;

  typedef struct {
    action_t              act;
    logic [FRAG_W-1:0]    frag;
    logic [BYTES_W-1:0]   offset;
    logic [CHUNK_W-1:0]   chunk;
    logic [RETRY_W-1:0]   tries;
  } frag_result_t;

  class fragment_tracker;
    logic [BYTES_W-1:0] msg_bytes;
    logic [SESS_W-1:0]  session;
    logic [RETRY_W-1:0] retry_limit;
    bit                 busy;
    logic [FRAG_W-1:0]  cur_frag;
    logic [BYTES_W-1:0] cur_offset;
    logic [RETRY_W-1:0] retries;
    frag_result_t       expected_actions[$];
    int                 errors;
    int                 n_items;
    int                 n_results;
    int                 action_seen[4];

    function new();
      msg_bytes   = '0;
      session     = '0;
      retry_limit = 8'd3;
      busy        = 1'b0;
      cur_frag    = '0;
      cur_offset  = '0;
      retries     = '0;
      errors      = 0;
      n_items     = 0;
      n_results   = 0;
      foreach (action_seen[i]) action_seen[i] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [BYTES_W-1:0] value);
      case (idx)
        REG_MESSAGE_BYTES: msg_bytes = value;
        REG_SESSION:       session = value[SESS_W-1:0];
        REG_RETRY_LIMIT:   retry_limit = value[RETRY_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [CHUNK_W-1:0] chunk_now();
      logic [BYTES_W-1:0] left;
      if (cur_offset >= msg_bytes) return '0;
      left = msg_bytes - cur_offset;
      return (left < FRAG_BYTES) ? left[CHUNK_W-1:0] : CHUNK_W'(FRAG_BYTES);
    endfunction

    function frag_result_t outcome(action_t act, bit describe);
      frag_result_t r;
      r.act    = act;
      r.frag   = describe ? cur_frag : '0;
      r.offset = describe ? cur_offset : '0;
      r.chunk  = describe ? chunk_now() : '0;
      r.tries  = describe ? retries : '0;
      return r;
    endfunction

    function void note_event(logic [1:0] ev, logic good, logic [SESS_W-1:0] rsess,
                             logic [1:0] rkind, logic [SEQ_W-1:0] rseq);
      logic [BYTES_W:0] next_offset;
      frag_result_t     r;
      n_items++;
      if (ev == OP_START) begin
        cur_frag   = '0;
        cur_offset = '0;
        retries    = '0;
        if (msg_bytes == 0) begin
          busy = 1'b0;
          r = outcome(ACT_DONE, 1'b0);
        end else if (retry_limit == 0) begin
          busy = 1'b0;
          r = outcome(ACT_ABORT, 1'b1);
        end else begin
          busy = 1'b1;
          r = outcome(ACT_SEND, 1'b1);
        end
      end else if (ev == OP_NONE || !busy) begin
        r = outcome(ACT_IGNORE, 1'b0);
      end else if (ev == OP_REPLY && good && rsess == session && rkind == KIND_ACK &&
                   rseq == {{(SEQ_W-FRAG_W){1'b0}}, cur_frag}) begin
        next_offset = {1'b0, cur_offset} + (BYTES_W+1)'(FRAG_BYTES);
        if (next_offset >= {1'b0, msg_bytes}) begin
          busy       = 1'b0;
          cur_frag   = '0;
          cur_offset = '0;
          retries    = '0;
          r = outcome(ACT_DONE, 1'b0);
        end else begin
          cur_offset = next_offset[BYTES_W-1:0];
          cur_frag   = cur_frag + 1'b1;
          retries    = '0;
          r = outcome(ACT_SEND, 1'b1);
        end
      end else begin
        if (retries != 8'hFF) retries = retries + 1'b1;
        if (retries >= retry_limit) begin
          busy = 1'b0;
          r = outcome(ACT_ABORT, 1'b1);
        end else begin
          r = outcome(ACT_SEND, 1'b1);
        end
      end
      expected_actions.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(frag_result_t got);
      frag_result_t want;
      n_results++;
      if (!$isunknown(got.act)) action_seen[got.act]++;
      if (expected_actions.size() == 0) begin
        $error("action: expected none, got %0d", got.act);
        errors++;
        return;
      end
      want = expected_actions.pop_front();
      check_field("action", want.act, got.act);
      check_field("fragment_number", want.frag, got.frag);
      check_field("byte_offset", want.offset, got.offset);
      check_field("chunk_length", want.chunk, got.chunk);
      check_field("attempt_count", want.tries, got.tries);
    endfunction

    function int pending();
      return expected_actions.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [1:0]          cfg_index;
  logic [BYTES_W-1:0]  cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          op;
  logic                frame_good;
  logic [SESS_W-1:0]   reply_session;
  logic [1:0]          reply_kind;
  logic [SEQ_W-1:0]    reply_sequence;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          action;
  logic [FRAG_W-1:0]   fragment_number;
  logic [BYTES_W-1:0]  byte_offset;
  logic [CHUNK_W-1:0]  chunk_length;
  logic [RETRY_W-1:0]  attempt_count;

  bit calm;
  int hold_requests;
  int hold_served;

  fragment_tracker tracker = new();

  stop_and_wait_fragment_sender #(
    .FRAGMENT_BYTES(FRAG_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .frame_good(frame_good),
    .reply_session(reply_session),
    .reply_kind(reply_kind),
    .reply_sequence(reply_sequence),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .action(action),
    .fragment_number(fragment_number),
    .byte_offset(byte_offset),
    .chunk_length(chunk_length),
    .attempt_count(attempt_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_stall = 1'b0;
    hold_served = 0;
    forever begin
      @(negedge clk);
      if (hold_served < hold_requests) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_served++;
      end else if (calm) begin
        out_stall = 1'b0;
      end else begin
        out_stall = ($urandom_range(0, 99) < 25);
      end
    end
  end

  always @(posedge clk) begin
    frag_result_t got;
    if (!rst) begin
      if (in_valid && !in_stall)
        tracker.note_event(op, frame_good, reply_session, reply_kind, reply_sequence);
      if (out_valid && !out_stall) begin
        got.act    = action_t'(action);
        got.frag   = fragment_number;
        got.offset = byte_offset;
        got.chunk  = chunk_length;
        got.tries  = attempt_count;
        tracker.check_result(got);
      end
    end
  end

  task automatic offer(logic [1:0] ev, logic good, logic [SESS_W-1:0] rsess,
                       logic [1:0] rkind, logic [SEQ_W-1:0] rseq);
    in_valid       = 1'b1;
    op             = ev;
    frame_good     = good;
    reply_session  = rsess;
    reply_kind     = rkind;
    reply_sequence = rseq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 99) < 25) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic settle();
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [BYTES_W-1:0] value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_write = 1'b0;
    tracker.write_reg(idx, value);
  endtask

  task automatic phase_config(int p);
    logic [BYTES_W-1:0] msg;
    logic [SESS_W-1:0]  sess;
    logic [RETRY_W-1:0] lim;
    int                 pick;
    case (p)
      0: begin
        msg = 24'd480;
        sess = 16'h0000;
        lim = 8'd3;
      end
      1: begin
        msg = 24'hFFFFFF;
        sess = 16'hFFFF;
        lim = 8'd255;
      end
      2: begin
        msg = 24'd1;
        sess = 16'($urandom);
        lim = 8'd1;
      end
      3: begin
        msg = 24'($urandom_range(1, 3000));
        sess = 16'($urandom);
        lim = 8'd0;
      end
      default: begin
        pick = $urandom_range(0, 9);
        if (pick == 0) msg = 24'(FRAG_BYTES * $urandom_range(1, 6));
        else if (pick == 1) msg = 24'hFFFFFF;
        else if (pick == 2) msg = '0;
        else msg = 24'($urandom_range(1, 2500));
        pick = $urandom_range(0, 9);
        if (pick == 0) sess = 16'h0000;
        else if (pick == 1) sess = 16'hFFFF;
        else sess = 16'($urandom);
        pick = $urandom_range(0, 19);
        if (pick == 0) lim = 8'd255;
        else if (pick == 1) lim = 8'd0;
        else lim = 8'($urandom_range(1, 6));
      end
    endcase
    write_reg(REG_MESSAGE_BYTES, msg);
    write_reg(REG_SESSION, {{(BYTES_W-SESS_W){1'b0}}, sess});
    write_reg(REG_RETRY_LIMIT, {{(BYTES_W-RETRY_W){1'b0}}, lim});
  endtask

  // mostly matching ACKs for the current fragment, some corrupted, some noise
  task automatic random_event();
    int                 r;
    logic [1:0]         ev;
    logic               good;
    logic [SESS_W-1:0]  rsess;
    logic [1:0]         rkind;
    logic [SEQ_W-1:0]   rseq;
    r     = $urandom_range(0, 99);
    ev    = OP_REPLY;
    good  = 1'b1;
    rsess = tracker.session;
    rkind = KIND_ACK;
    rseq  = {{(SEQ_W-FRAG_W){1'b0}}, tracker.cur_frag};
    if ((!tracker.busy && r < 60) || r < 4) begin
      ev = OP_START;
      good = 1'($urandom);
      rsess = 16'($urandom);
      rkind = 2'($urandom);
      rseq = $urandom;
    end else if (r < 8) begin
      ev = OP_NONE;
      good = 1'($urandom);
      rsess = 16'($urandom);
      rkind = 2'($urandom);
      rseq = $urandom;
    end else if (r < 12) begin
      ev = 2'($urandom);
      good = 1'($urandom);
      rsess = 16'($urandom);
      rkind = 2'($urandom);
      rseq = $urandom;
    end else if (r < 17) begin
      ev = OP_TIMEOUT;
      good = 1'($urandom);
      rkind = 2'($urandom);
    end else if (r < 45) begin
      case ($urandom_range(0, 3))
        0: good = 1'b0;
        1: rsess = rsess ^ (16'd1 << $urandom_range(0, 15));
        2: rkind = 2'($urandom_range(1, 3));
        default: rseq = rseq ^ (32'd1 << $urandom_range(0, 31));
      endcase
    end
    offer(ev, good, rsess, rkind, rseq);
  endtask

  initial begin
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    op             = '0;
    frame_good     = 1'b0;
    reply_session  = '0;
    reply_kind     = '0;
    reply_sequence = '0;
    calm           = 1'b0;
    hold_requests  = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // idle block: responses, timeouts and the unused op are ignored; empty message
    offer(OP_TIMEOUT, 1'b1, 16'h0000, KIND_ACK, 32'd0);
    offer(OP_REPLY, 1'b1, 16'h0000, KIND_ACK, 32'd0);
    offer(OP_NONE, 1'b0, 16'hFFFF, KIND_RSVD, 32'hFFFF_FFFF);
    offer(OP_START, 1'b0, 16'h0000, KIND_ACK, 32'd0);

    // zero retry limit aborts on start
    settle();
    write_reg(REG_MESSAGE_BYTES, 24'd1000);
    write_reg(REG_SESSION, 24'h00FFFF);
    write_reg(REG_RETRY_LIMIT, 24'd0);
    offer(OP_START, 1'b1, 16'hFFFF, KIND_ACK, 32'd0);

    // three fragments, every kind of failed attempt, restart while busy
    settle();
    write_reg(REG_RETRY_LIMIT, 24'd255);
    offer(OP_START, 1'b1, 16'hFFFF, KIND_ACK, 32'd0);
    offer(OP_REPLY, 1'b1, 16'hFFFF, KIND_ACK, 32'd0);
    offer(OP_REPLY, 1'b1, 16'hFFFF, KIND_NACK, 32'd1);
    offer(OP_TIMEOUT, 1'b1, 16'hFFFF, KIND_ACK, 32'd1);
    offer(OP_REPLY, 1'b0, 16'hFFFF, KIND_ACK, 32'd1);
    offer(OP_REPLY, 1'b1, 16'h7FFF, KIND_ACK, 32'd1);
    offer(OP_REPLY, 1'b1, 16'hFFFF, KIND_ACK, 32'h0001_0001);
    offer(OP_REPLY, 1'b1, 16'hFFFF, KIND_OTHER, 32'd1);
    offer(OP_REPLY, 1'b1, 16'hFFFF, KIND_RSVD, 32'd1);
    offer(OP_REPLY, 1'b1, 16'hFFFF, KIND_ACK, 32'd1);
    offer(OP_NONE, 1'b1, 16'hFFFF, KIND_ACK, 32'd2);
    offer(OP_START, 1'b1, 16'hFFFF, KIND_ACK, 32'd0);
    offer(OP_REPLY, 1'b1, 16'hFFFF, KIND_ACK, 32'd0);
    offer(OP_REPLY, 1'b1, 16'hFFFF, KIND_ACK, 32'd1);
    offer(OP_REPLY, 1'b1, 16'hFFFF, KIND_ACK, 32'd2);

    // retry limit of one, so the first failed attempt aborts; message of exactly one full fragment
    settle();
    write_reg(REG_RETRY_LIMIT, 24'd1);
    write_reg(REG_MESSAGE_BYTES, 24'd479);
    offer(OP_START, 1'b0, 16'h0000, KIND_ACK, 32'd0);
    offer(OP_REPLY, 1'b1, 16'hFFFF, KIND_NACK, 32'd0);
    offer(OP_START, 1'b0, 16'h0000, KIND_ACK, 32'd0);
    offer(OP_REPLY, 1'b1, 16'hFFFF, KIND_ACK, 32'd0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      phase_config(p);
      calm = (p == 1);
      if (p == 5) hold_requests++;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 8 && n == ITEMS_PER_PHASE / 2) settle();
        sender_gap();
        random_event();
      end
    end

    calm = 1'b0;
    settle();
    repeat (5) @(posedge clk);
    $display("Covered %0d events over %0d register phases, %0d results checked",
             tracker.n_items, PHASES + 4, tracker.n_results);
    $display("Results seen: %0d send, %0d finished, %0d aborted, %0d ignored",
             tracker.action_seen[ACT_SEND], tracker.action_seen[ACT_DONE],
             tracker.action_seen[ACT_ABORT], tracker.action_seen[ACT_IGNORE]);
    if (tracker.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
